FILE: sv/ffua_pkg.sv
// shared constants and control/status types for the first-fit unit allocator
`default_nettype none

package ffua_pkg;

    localparam int NUM_UNITS = 512;
    localparam int OWNER_W   = 8;
    localparam int IDX_W     = $clog2(NUM_UNITS);
    localparam int CNT_W     = $clog2(NUM_UNITS + 1);
    localparam int ENTRY_W   = OWNER_W + 1;

    // port field widths
    localparam int CMD_W     = 1;
    localparam int OWN_ID_W  = 8;
    localparam int REQ_W     = 10;
    localparam int START_W   = 9;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef struct packed {
        logic clear_en;
        logic load;
        logic scan_en;
        logic fill_en;
        logic finish;
        logic fail;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic is_free;
        logic bad_size;
        logic hit;
        logic scan_end;
        logic fill_last;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: sv/ffua_req_if.sv
// request channel: command, owner and size
`default_nettype none

interface ffua_req_if import ffua_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [OWN_ID_W-1:0] owner_id;
    logic [REQ_W-1:0]    request_size;

    modport source (output valid, output command, output owner_id, output request_size,
                    input ready);
    modport sink   (input valid, input command, input owner_id, input request_size,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/ffua_rsp_if.sv
// response channel: status and start unit
`default_nettype none

interface ffua_rsp_if import ffua_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               status;
    logic [START_W-1:0] start_unit;

    modport source (output valid, output status, output start_unit, input ready);
    modport sink   (input valid, input status, input start_unit, output ready);
endinterface

`default_nettype wire

FILE: sv/ffua_dp.sv
// datapath: unit table memory, scan and fill counters, result register
`default_nettype none

module ffua_dp import ffua_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    input  wire logic                i_command,
    input  wire logic [OWN_ID_W-1:0] i_owner_id,
    input  wire logic [REQ_W-1:0]    i_request_size,
    output t_dp_sts                  o_sts,
    output logic                     o_status,
    output logic [START_W-1:0]       o_start_unit
);

    logic [ENTRY_W-1:0] r_mem [NUM_UNITS];
    logic [ENTRY_W-1:0] r_rd_data;

    logic [CNT_W-1:0]   r_idx;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_dat_idx;
    logic               r_cmd;
    logic [OWNER_W-1:0] r_owner;
    logic [REQ_W-1:0]   r_size;
    logic [CNT_W-1:0]   r_run_len;
    logic [IDX_W-1:0]   r_run_start;
    logic [IDX_W-1:0]   r_fill_idx;
    logic [IDX_W-1:0]   r_fill_last;
    logic               r_out_status;
    logic [START_W-1:0] r_out_start;

    logic               used;
    logic [OWNER_W-1:0] own;
    logic               proc;
    logic               issue;
    logic [CNT_W-1:0]   len_inc;
    logic [IDX_W-1:0]   hit_start;
    logic [CNT_W-1:0]   fill_end;
    logic               hit;
    logic               free_wr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    always_comb begin
        used      = r_rd_data[ENTRY_W-1];
        own       = r_rd_data[OWNER_W-1:0];
        proc      = i_cmd.scan_en && r_rd_vld;
        issue     = i_cmd.scan_en && (r_idx < CNT_W'(NUM_UNITS));
        len_inc   = r_run_len + CNT_W'(1);
        hit_start = (r_run_len == '0) ? r_dat_idx : r_run_start;
        fill_end  = CNT_W'(hit_start) + CNT_W'(r_size) - CNT_W'(1);
        hit       = proc && (r_cmd == CMD_ALLOC) && !used && (len_inc == CNT_W'(r_size));
        free_wr   = proc && (r_cmd == CMD_FREE) && used && (own == r_owner);

        // only one writer is active at a time
        wr_en   = 1'b0;
        wr_addr = r_fill_idx;
        wr_data = {1'b1, r_owner};
        if (i_cmd.clear_en) begin
            wr_en   = 1'b1;
            wr_addr = r_idx[IDX_W-1:0];
            wr_data = '0;
        end else if (free_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_dat_idx;
            wr_data = '0;
        end else if (i_cmd.fill_en) begin
            wr_en   = 1'b1;
        end

        o_sts.clear_done = i_cmd.clear_en && (r_idx[IDX_W-1:0] == IDX_W'(NUM_UNITS - 1));
        o_sts.is_free    = (r_cmd == CMD_FREE);
        o_sts.bad_size   = (r_size == '0) || ({1'b0, r_size} > (REQ_W + 1)'(NUM_UNITS));
        o_sts.hit        = hit;
        o_sts.scan_end   = proc && (r_dat_idx == IDX_W'(NUM_UNITS - 1));
        o_sts.fill_last  = i_cmd.fill_en && (r_fill_idx == r_fill_last);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.clear_en || issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            r_rd_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dat_idx <= r_idx[IDX_W-1:0];
        if (i_cmd.load) begin
            r_cmd     <= i_command;
            r_owner   <= i_owner_id[OWNER_W-1:0];
            r_size    <= i_request_size;
            r_run_len <= '0;
        end else if (proc && (r_cmd == CMD_ALLOC)) begin
            if (!used) begin
                r_run_len   <= len_inc;
                r_run_start <= hit_start;
            end else begin
                r_run_len <= '0;
            end
        end
        if (hit) begin
            r_fill_idx  <= hit_start;
            r_fill_last <= fill_end[IDX_W-1:0];
        end else if (i_cmd.fill_en) begin
            r_fill_idx <= r_fill_idx + IDX_W'(1);
        end
        if (i_cmd.finish) begin
            r_out_status <= i_cmd.fail ? ST_FAIL : ST_OK;
            r_out_start  <= (i_cmd.fail || (r_cmd == CMD_FREE)) ? '0 : START_W'(r_run_start);
        end
    end

    assign o_status     = r_out_status;
    assign o_start_unit = r_out_start;

endmodule

`default_nettype wire

FILE: sv/ffua_ctrl.sv
// controller: clearing pass, scan, fill and result handoff sequencing
`default_nettype none

module ffua_ctrl import ffua_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_dp_sts i_sts,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CHECK = 6'b000100,
        S_SCAN  = 6'b001000,
        S_FILL  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_fail, n_fail;
    logic   r_out_vld, n_out_vld;
    logic   out_free;

    always_comb begin
        n_state  = r_state;
        n_fail   = r_fail;
        out_free = !r_out_vld || i_out_ready;
        o_cmd    = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.is_free && i_sts.bad_size) begin
                    n_fail  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_FILL;
                end else if (i_sts.scan_end) begin
                    n_fail  = !i_sts.is_free;
                    n_state = S_DONE;
                end
            end
            S_FILL: begin
                o_cmd.fill_en = 1'b1;
                if (i_sts.fill_last) begin
                    n_fail  = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.fail   = r_fail;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a new result wins over the transfer of the old one
        if (o_cmd.finish) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_fail    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fail    <= n_fail;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

FILE: sv/first_fit_unit_allocator_unit.sv
// top level of the first-fit contiguous unit allocator
//
//  channel  dir  fields                              transfer
//  i_req    in   command, owner_id, request_size     valid & ready
//  o_rsp    out  status, start_unit                  valid & ready
//
// after reset the unit table is cleared one entry per cycle with i_req.ready
// low. an allocate runs a size check, table reads through one read port,
// request_size fill writes and a result handoff; a free runs the check, a read
// pass over the table and the handoff. one command is
// worked at a time. the response register holds a result while the next
// command runs; only its handoff waits on o_rsp.ready.
`default_nettype none

module first_fit_unit_allocator_unit import ffua_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ffua_req_if.sink  i_req,
    ffua_rsp_if.source o_rsp
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    ffua_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sts       (dp_sts),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (dp_cmd)
    );

    ffua_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_command      (i_req.command),
        .i_owner_id     (i_req.owner_id),
        .i_request_size (i_req.request_size),
        .o_sts          (dp_sts),
        .o_status       (o_rsp.status),
        .o_start_unit   (o_rsp.start_unit)
    );

endmodule

`default_nettype wire
